### sv/dtls_pkg.sv
// dtls_pkg: shared constants, types and helpers of the density traffic light sequencer
`timescale 1ns / 1ps

package dtls_pkg;

  // lane arrangement
  localparam int LANES        = 4;
  localparam int LANE_W       = $clog2(LANES);
  localparam int COUNT_INPUTS = 4;

  // field widths
  localparam int CNT_W   = 10;
  localparam int REG_W   = 16;
  localparam int MASK_W  = 4;
  localparam int LANE_OW = 2;
  localparam int IDX_W   = 2;
  localparam int PROD_W  = CNT_W + REG_W;
  localparam int SUM_W   = PROD_W + 1;

  // register reset values
  localparam logic [REG_W-1:0] BASE_GREEN_RST = 16'd5000;
  localparam logic [REG_W-1:0] PER_VEH_RST    = 16'd2000;
  localparam logic [REG_W-1:0] MAX_GREEN_RST  = 16'd30000;
  localparam logic [REG_W-1:0] YELLOW_RST     = 16'd2000;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_BASE_GREEN = 2'd0,
    REG_PER_VEH    = 2'd1,
    REG_MAX_GREEN  = 2'd2,
    REG_YELLOW     = 2'd3
  } cfg_reg_e;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [LANE_W-1:0] lane_t;

  // a zero length phase still lasts one tick
  function automatic logic [REG_W-1:0] phase_len(input logic [REG_W-1:0] t);
    return (t == '0) ? REG_W'(1) : t;
  endfunction

endpackage

### sv/dtls_if.sv
// dtls_if: handshake channel interfaces of the sequencer
`timescale 1ns / 1ps

interface dtls_in_if;
  import dtls_pkg::*;
  logic   valid;
  logic   ready;
  logic   mode;
  count_t count_a;
  count_t count_b;
  count_t count_c;
  count_t count_d;
  modport source (output valid, mode, count_a, count_b, count_c, count_d, input ready);
  modport sink   (input valid, mode, count_a, count_b, count_c, count_d, output ready);
endinterface

interface dtls_out_if;
  import dtls_pkg::*;
  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  red_mask;
  logic [MASK_W-1:0]  yellow_mask;
  logic [MASK_W-1:0]  green_mask;
  logic [LANE_OW-1:0] active_lane;
  modport source (output valid, red_mask, yellow_mask, green_mask, active_lane, input ready);
  modport sink   (input valid, red_mask, yellow_mask, green_mask, active_lane, output ready);
endinterface

interface dtls_cfg_if;
  import dtls_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [REG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/density_traffic_light_sequencer.sv
// density_traffic_light_sequencer: four lane adaptive traffic light sequencer, top level
//
//   channel  dir  transfer carries
//   cfg_i    in   register index and 16 bit value (base, per vehicle, max green, yellow)
//   in_i     in   mode (tick or update) and four 10 bit vehicle counts
//   out_o    out  red, yellow and green lamp masks and the lane being served
//
// one item per cycle unless stalled: each transfer updates the phase state in the same
// cycle, its lamp masks land in the result register, shown on out_o from the next cycle
// the green time path is one 10x16 multiply, an add and a compare against the cap
// in_i stalls only while a result waits in the result register and out_o is not ready
// reset (async, active low) leaves the sequencer idle with no result pending, registers at their defaults
// cfg_i is always ready; writes are expected only while no transfer is in flight
`timescale 1ns / 1ps

module density_traffic_light_sequencer
  import dtls_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  dtls_cfg_if.sink          cfg_i,
  dtls_in_if.sink           in_i,
  dtls_out_if.source        out_o
);

  // configuration registers
  logic [REG_W-1:0] base_green_q, per_veh_q, max_green_q, yellow_q;

  // phase state
  logic             running_q, running_d;
  lane_t            lane_q, lane_d;
  logic             in_yellow_q, in_yellow_d;
  logic [REG_W-1:0] ticks_q, ticks_d;
  count_t           pending_q [LANES];
  count_t           pending_d [LANES];
  count_t           active_q  [LANES];
  count_t           active_d  [LANES];

  // result register
  logic               out_valid_q;
  logic [MASK_W-1:0]  red_q, yel_mask_q, green_q;
  logic [LANE_OW-1:0] lane_out_q;

  logic   in_fire;
  logic   upd;
  count_t in_counts [COUNT_INPUTS];

  // green time datapath
  lane_t            lane_next;
  lane_t            green_lane;
  count_t           green_cnt;
  logic [PROD_W-1:0] green_prod;
  logic [SUM_W-1:0]  green_sum;
  logic [REG_W-1:0]  green_ticks;
  logic              start_green;

  // lamp masks of the state after the item
  logic [LANES-1:0] all_lanes, lane_bit, red_n, yel_n, grn_n;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign upd         = in_i.mode;

  assign in_counts[0] = in_i.count_a;
  assign in_counts[1] = in_i.count_b;
  assign in_counts[2] = in_i.count_c;
  assign in_counts[3] = in_i.count_d;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_green_q <= BASE_GREEN_RST;
      per_veh_q    <= PER_VEH_RST;
      max_green_q  <= MAX_GREEN_RST;
      yellow_q     <= YELLOW_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_BASE_GREEN: base_green_q <= cfg_i.data;
        REG_PER_VEH:    per_veh_q    <= cfg_i.data;
        REG_MAX_GREEN:  max_green_q  <= cfg_i.data;
        REG_YELLOW:     yellow_q     <= cfg_i.data;
        default:        ;
      endcase
    end
  end

  // pending counts: an update transfer overwrites them, lanes beyond the inputs stay zero
  always_comb begin
    pending_d = pending_q;
    if (in_fire && upd) begin
      for (int i = 0; i < COUNT_INPUTS; i++) begin
        if (i < LANES) pending_d[i] = in_counts[i];
      end
    end
  end

  // lane that a new green would serve: lane A when starting from idle
  assign lane_next  = (lane_q == LANE_W'(LANES - 1)) ? '0 : lane_q + 1'b1;
  assign green_lane = running_q ? lane_next : '0;

  // lane A picks up the pending counts as its green begins
  assign green_cnt   = (green_lane == '0) ? pending_d[0] : active_q[green_lane];
  assign green_prod  = PROD_W'(green_cnt) * PROD_W'(per_veh_q);
  assign green_sum   = SUM_W'(base_green_q) + SUM_W'(green_prod);
  assign green_ticks = phase_len((green_sum > SUM_W'(max_green_q)) ? max_green_q
                                                                   : green_sum[REG_W-1:0]);

  // phase sequencing
  always_comb begin
    running_d   = running_q;
    lane_d      = lane_q;
    in_yellow_d = in_yellow_q;
    ticks_d     = ticks_q;
    active_d    = active_q;
    start_green = 1'b0;
    if (in_fire) begin
      if (!running_q) begin
        // first item after reset starts lane A, without counting down
        running_d   = 1'b1;
        start_green = 1'b1;
      end else if (!upd) begin
        if (ticks_q > REG_W'(1)) begin
          ticks_d = ticks_q - 1'b1;
        end else if (!in_yellow_q) begin
          in_yellow_d = 1'b1;
          ticks_d     = phase_len(yellow_q);
        end else begin
          start_green = 1'b1;
        end
      end
    end
    if (start_green) begin
      lane_d      = green_lane;
      in_yellow_d = 1'b0;
      ticks_d     = green_ticks;
      if (green_lane == '0) active_d = pending_d;
    end
  end

  // lamps after the item
  always_comb begin
    all_lanes = '1;
    lane_bit  = LANES'(1) << lane_d;
    red_n     = all_lanes;
    yel_n     = '0;
    grn_n     = '0;
    if (running_d) begin
      red_n = all_lanes & ~lane_bit;
      if (in_yellow_d) yel_n = lane_bit;
      else             grn_n = lane_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      lane_q      <= '0;
      in_yellow_q <= 1'b0;
      ticks_q     <= '0;
      for (int i = 0; i < LANES; i++) begin
        pending_q[i] <= '0;
        active_q[i]  <= '0;
      end
    end else begin
      running_q   <= running_d;
      lane_q      <= lane_d;
      in_yellow_q <= in_yellow_d;
      ticks_q     <= ticks_d;
      pending_q   <= pending_d;
      active_q    <= active_d;
    end
  end

  // result register: holds until out_o takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      red_q      <= MASK_W'(red_n);
      yel_mask_q <= MASK_W'(yel_n);
      green_q    <= MASK_W'(grn_n);
      lane_out_q <= running_d ? LANE_OW'(lane_d) : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.red_mask    = red_q;
  assign out_o.yellow_mask = yel_mask_q;
  assign out_o.green_mask  = green_q;
  assign out_o.active_lane = lane_out_q;

`ifndef SYNTHESIS
  // idle means lane A, not yellow
  a_idle_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (!in_yellow_q && lane_q == '0))
    else $error("idle sequencer left lane A or yellow set");

  // a running phase always has time left
  a_ticks_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (ticks_q != '0))
    else $error("running phase with zero ticks left");

  // any transfer starts the sequencer
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> running_q)
    else $error("sequencer not running after a transfer");

  // an update while running leaves the countdown alone
  a_update_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && upd && running_q) |=> (ticks_q == $past(ticks_q) && lane_q == $past(lane_q)))
    else $error("update transfer moved the phase");

  // at most one lane is lit green or yellow
  a_one_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0(green_q | yel_mask_q))
    else $error("more than one lane lit");
`endif

endmodule
